FILE: design/nsu_pkg.sv
// Shared types, constants and helpers for the neuron soma update core.
// No dependencies; imported by every module of the core.
package nsu_pkg;

    localparam int IDX_W       = 8;
    localparam int P_W         = 32;
    localparam int TS_W        = 16;
    localparam int LEAK_W      = 16;
    localparam int MASK_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int ACC_W       = P_W + 4;

    localparam int NEURONS_DEF = 256;
    localparam int MAX_GAP_DEF = 255;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [1:0] {
        MODEL_LIF         = 2'd0,
        MODEL_IF          = 2'd1,
        MODEL_LINEAR      = 2'd2,
        MODEL_TOWARD_ZERO = 2'd3
    } t_model;

    typedef enum logic [1:0] {
        RST_HARD = 2'd0,
        RST_SOFT = 2'd1,
        RST_SAT  = 2'd2,
        RST_NONE = 2'd3
    } t_rmode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL      = 3'd0,
        CFG_FIRE_TH    = 3'd1,
        CFG_REV_TH     = 3'd2,
        CFG_RST_LEVEL  = 3'd3,
        CFG_REV_LEVEL  = 3'd4,
        CFG_LEAK       = 3'd5,
        CFG_RST_MODES  = 3'd6,
        CFG_JIT_MASK   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_model                  model;
        logic signed [P_W-1:0]   fire_th;
        logic signed [P_W-1:0]   rev_th;
        logic signed [P_W-1:0]   rst_level;
        logic signed [P_W-1:0]   rev_level;
        logic [LEAK_W-1:0]       leak_amount;
        t_rmode                  pos_mode;
        t_rmode                  rev_mode;
        logic [MASK_W-1:0]       jitter_mask;
    } t_cfg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LEAK,
        S_SUM,
        S_DECIDE,
        S_PUSH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic load;
        logic leak_step;
        logic sum;
        logic decide;
        logic push;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic leak_done;
        logic out_free;
    } t_sts;

    function automatic logic signed [P_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-P_W+1){1'b0}}, {(P_W-1){1'b1}}};
        lo = {{(ACC_W-P_W+1){1'b1}}, {(P_W-1){1'b0}}};
        if (x > hi) begin
            sat32 = hi[P_W-1:0];
        end else if (x < lo) begin
            sat32 = lo[P_W-1:0];
        end else begin
            sat32 = x[P_W-1:0];
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sext(input logic signed [P_W-1:0] x);
        sext = {{(ACC_W-P_W){x[P_W-1]}}, x};
    endfunction

endpackage

FILE: design/nsu_cfg_regs.sv
// Configuration register bank of the neuron soma update core.
// Depends on nsu_pkg.
module nsu_cfg_regs
    import nsu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.model       <= MODEL_LIF;
            r_cfg.fire_th     <= '0;
            r_cfg.rev_th      <= '0;
            r_cfg.rst_level   <= '0;
            r_cfg.rev_level   <= '0;
            r_cfg.leak_amount <= '1;
            r_cfg.pos_mode    <= RST_HARD;
            r_cfg.rev_mode    <= RST_HARD;
            r_cfg.jitter_mask <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODEL:     r_cfg.model       <= t_model'(i_cfg_data[1:0]);
                CFG_FIRE_TH:   r_cfg.fire_th     <= i_cfg_data;
                CFG_REV_TH:    r_cfg.rev_th      <= i_cfg_data;
                CFG_RST_LEVEL: r_cfg.rst_level   <= i_cfg_data;
                CFG_REV_LEVEL: r_cfg.rev_level   <= i_cfg_data;
                CFG_LEAK:      r_cfg.leak_amount <= i_cfg_data[LEAK_W-1:0];
                CFG_RST_MODES: begin
                    r_cfg.pos_mode <= t_rmode'(i_cfg_data[1:0]);
                    r_cfg.rev_mode <= t_rmode'(i_cfg_data[3:2]);
                end
                CFG_JIT_MASK:  r_cfg.jitter_mask <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: design/nsu_ctrl.sv
// Sequencing state machine of the neuron soma update core.
// Depends on nsu_pkg; drives the datapath through t_cmd, reads t_sts.
module nsu_ctrl
    import nsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_sts.clear_done) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_READ;
            S_READ:   n_state = S_LEAK;
            S_LEAK:   if (i_sts.leak_done) n_state = S_SUM;
            S_SUM:    n_state = S_DECIDE;
            S_DECIDE: n_state = S_PUSH;
            S_PUSH:   if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR:  o_cmd.clear = 1'b1;
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_READ:   o_cmd.load = 1'b1;
            S_LEAK:   o_cmd.leak_step = !i_sts.leak_done;
            S_SUM:    o_cmd.sum = 1'b1;
            S_DECIDE: o_cmd.decide = 1'b1;
            S_PUSH:   o_cmd.push = 1'b1;
            default: ;
        endcase
    end

endmodule

FILE: design/nsu_datapath.sv
// Datapath of the neuron soma update core: state memories, leak unit,
// threshold logic, jitter LFSR and output register. Depends on nsu_pkg.
module nsu_datapath
    import nsu_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF,
    parameter int MAX_GAP = MAX_GAP_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [IDX_W-1:0]      i_neuron_index,
    input  logic signed [P_W-1:0] i_input_current,
    input  logic signed [P_W-1:0] i_bias_current,
    input  logic [TS_W-1:0]       i_timestep_now,
    input  logic                  i_forced,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_neuron_out,
    output logic                  o_fired,
    output logic                  o_reverse_hit,
    output logic signed [P_W-1:0] o_new_potential
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int SW = $clog2(MAX_GAP + 1);
    localparam int XW = IDX_W + AW;
    localparam logic [XW-1:0]   NEU_X   = XW'(NEURONS);
    localparam logic [AW-1:0]   LAST_A  = AW'(NEURONS - 1);
    localparam logic [TS_W:0]   GAP_X   = (TS_W + 1)'(MAX_GAP);

    // state memories
    logic signed [P_W-1:0] r_mem_p   [NEURONS];
    logic [TS_W-1:0]       r_mem_nls [NEURONS];
    logic signed [P_W-1:0] r_rd_p;
    logic [TS_W-1:0]       r_rd_nls;

    // item registers
    logic [IDX_W-1:0]      r_idx;
    logic [AW-1:0]         r_addr;
    logic                  r_oor;
    logic signed [P_W-1:0] r_cur;
    logic signed [P_W-1:0] r_bias;
    logic [TS_W-1:0]       r_now;
    logic                  r_forced;
    logic [TS_W-1:0]       r_nls_new;
    logic [SW-1:0]         r_steps;
    logic signed [P_W-1:0] r_p;
    logic [SW+LEAK_W-1:0]  r_prod;
    logic                  r_prod_vld;
    logic                  r_fired;
    logic                  r_rev;
    logic signed [P_W-1:0] r_res_p;
    logic [AW-1:0]         r_clr_addr;
    logic [15:0]           r_lfsr;

    logic [XW-1:0]         idx_x;
    logic [AW-1:0]         in_addr;
    logic                  in_oor;

    assign idx_x   = {{AW{1'b0}}, i_neuron_index};
    assign in_addr = idx_x[AW-1:0];
    assign in_oor  = (idx_x >= NEU_X);

    // memory write port: clearing pass or the decide step
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic signed [P_W-1:0] mem_wp;
    logic [TS_W-1:0]       mem_wn;

    logic                  dec_fire;
    logic                  dec_rev;
    logic signed [P_W-1:0] dec_p;
    logic                  lfsr_adv;
    logic [15:0]           lfsr_nxt;

    always_comb begin
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wp = '0;
            mem_wn = '0;
        end else begin
            mem_we = i_cmd.decide && !r_oor;
            mem_wa = r_addr;
            mem_wp = dec_p;
            mem_wn = r_nls_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_p[mem_wa]   <= mem_wp;
            r_mem_nls[mem_wa] <= mem_wn;
        end
        if (i_cmd.capture) begin
            r_rd_p   <= r_mem_p[in_addr];
            r_rd_nls <= r_mem_nls[in_addr];
        end
    end

    // leak catch-up count
    logic [TS_W:0]   gap;
    logic            due;
    logic [SW-1:0]   steps_new;

    always_comb begin
        due       = (r_now >= r_rd_nls);
        gap       = {1'b0, r_now} - {1'b0, r_rd_nls} + 1'b1;
        steps_new = (gap > GAP_X) ? GAP_X[SW-1:0] : gap[SW-1:0];
        if (!due || r_oor) begin
            steps_new = '0;
        end
    end

    // one leak step
    logic [P_W-1:0]           lif_mag;
    logic [P_W+LEAK_W-1:0]    lif_prod;
    logic signed [P_W-1:0]    lif_q;
    logic signed [P_W-1:0]    leak_p;
    logic signed [ACC_W-1:0]  leak_x;
    logic signed [ACC_W-1:0]  prod_x;

    always_comb begin
        lif_mag  = r_p[P_W-1] ? P_W'(-r_p) : P_W'(r_p);
        lif_prod = lif_mag * i_cfg.leak_amount;
        lif_q    = lif_prod[P_W+LEAK_W-1:LEAK_W];
        leak_x   = {{(ACC_W-LEAK_W){1'b0}}, i_cfg.leak_amount};
        prod_x   = {{(ACC_W-SW-LEAK_W){1'b0}}, r_prod};
        case (i_cfg.model)
            MODEL_LIF:         leak_p = r_p[P_W-1] ? -lif_q : lif_q;
            MODEL_LINEAR:      leak_p = sat32(sext(r_p) + prod_x);
            MODEL_TOWARD_ZERO: begin
                if (r_p > 0) begin
                    leak_p = sat32(sext(r_p) - leak_x);
                end else if (r_p < 0) begin
                    leak_p = sat32(sext(r_p) + leak_x);
                end else begin
                    leak_p = r_p;
                end
            end
            default:           leak_p = r_p;
        endcase
    end

    assign o_sts.leak_done = (r_steps == '0) || (i_cfg.model == MODEL_IF)
                           || ((i_cfg.model == MODEL_LIF) && (r_p == '0));

    // threshold decision
    logic                    linear;
    logic [MASK_W-1:0]       jit;
    logic signed [ACC_W-1:0] v_x;

    always_comb begin
        lfsr_nxt = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};
        linear   = (i_cfg.model == MODEL_LINEAR) || (i_cfg.model == MODEL_TOWARD_ZERO);
        lfsr_adv = i_cmd.decide && linear && (i_cfg.jitter_mask != '0) && !r_oor;
        jit      = (i_cfg.jitter_mask != '0) ? (lfsr_nxt & i_cfg.jitter_mask) : '0;
        v_x      = sext(r_p) + {{(ACC_W-MASK_W){1'b0}}, jit};
        dec_fire = 1'b0;
        dec_rev  = 1'b0;
        dec_p    = r_p;
        if (!linear) begin
            dec_fire = r_forced ? (r_p > i_cfg.fire_th) : (r_p >= i_cfg.fire_th);
            if (dec_fire) begin
                dec_p = i_cfg.rst_level;
            end
        end else if (v_x >= sext(i_cfg.fire_th)) begin
            dec_fire = 1'b1;
            case (i_cfg.pos_mode)
                RST_HARD: dec_p = i_cfg.rst_level;
                RST_SOFT: dec_p = sat32(sext(r_p) - sext(i_cfg.fire_th));
                RST_SAT:  dec_p = i_cfg.fire_th;
                default:  dec_p = r_p;
            endcase
        end else if (v_x <= sext(i_cfg.rev_th)) begin
            dec_rev = 1'b1;
            case (i_cfg.rev_mode)
                RST_HARD: dec_p = i_cfg.rev_level;
                RST_SOFT: dec_p = sat32(sext(r_p) + sext(i_cfg.rev_th));
                RST_SAT:  dec_p = i_cfg.rev_th;
                default:  dec_p = r_p;
            endcase
        end
        if (r_oor) begin
            dec_fire = 1'b0;
            dec_rev  = 1'b0;
            dec_p    = '0;
        end
    end

    // item payload registers
    logic signed [P_W-1:0] n_p;

    always_comb begin
        n_p = r_p;
        if (i_cmd.load) begin
            n_p = r_oor ? '0 : r_rd_p;
        end else if (i_cmd.leak_step && !((i_cfg.model == MODEL_LINEAR) && !r_prod_vld)) begin
            n_p = leak_p;
        end else if (i_cmd.sum) begin
            n_p = sat32(sext(r_p) + sext(r_cur) + sext(r_bias));
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        if (i_cmd.capture) begin
            r_idx    <= i_neuron_index;
            r_addr   <= in_addr;
            r_oor    <= in_oor;
            r_cur    <= i_input_current;
            r_bias   <= i_bias_current;
            r_now    <= i_timestep_now;
            r_forced <= i_forced;
        end
        if (i_cmd.load) begin
            r_steps   <= steps_new;
            r_nls_new <= due ? r_now + 1'b1 : r_rd_nls;
        end else if (i_cmd.leak_step) begin
            if (i_cfg.model == MODEL_LINEAR) begin
                if (!r_prod_vld) begin
                    r_prod <= r_steps * i_cfg.leak_amount;
                end else begin
                    r_steps <= '0;
                end
            end else begin
                r_steps <= r_steps - 1'b1;
            end
        end
        if (i_cmd.decide) begin
            r_fired <= dec_fire;
            r_rev   <= dec_rev;
            r_res_p <= dec_p;
        end
    end

    // control registers
    logic out_load;

    assign o_sts.out_free   = !o_out_valid || !i_out_stall;
    assign o_sts.clear_done = (r_clr_addr == LAST_A);
    assign out_load         = i_cmd.push && o_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_lfsr      <= LFSR_SEED;
            r_prod_vld  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear && !o_sts.clear_done) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (lfsr_adv) begin
                r_lfsr <= lfsr_nxt;
            end
            if (i_cmd.load) begin
                r_prod_vld <= 1'b0;
            end else if (i_cmd.leak_step && (i_cfg.model == MODEL_LINEAR)) begin
                r_prod_vld <= 1'b1;
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_neuron_out    <= r_idx;
            o_fired         <= r_fired;
            o_reverse_hit   <= r_rev;
            o_new_potential <= r_res_p;
        end
    end

endmodule

FILE: design/neuron_soma_update_core.sv
// Top level of the neuron soma update core (LIF, IF, linear and toward-zero models).
// Depends on nsu_pkg, nsu_cfg_regs, nsu_ctrl and nsu_datapath.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-----------------------------------
//   in      | in        | i_in_valid / o_in_stall| index, current, bias, timestep,
//           |           |                        | forced
//   out     | out       | o_out_valid/i_out_stall| neuron, fired, reverse hit,
//           |           |                        | new potential
//   cfg     | in        | i_cfg_valid/o_cfg_ready| register index, data
//
// Per word: read, leak in the shared leak unit, sum, decide, push; the input
//   stalls until the push. Leak steps: LIF up to min(gap, MAX_GAP) multiplies (ends
//   early when the potential reaches zero), toward-zero leak min(gap, MAX_GAP)
//   steps, linear leak 2 (multiply, then add), IF 0.
// Reset: synchronous, active low. A clearing pass then zeroes both state
//   memories, one neuron per cycle; the input stalls meanwhile, config writes
//   are taken.
// Stalls: a finished word sits in the output register; the next input word is
//   accepted and processed, and waits only at its own output push.
module neuron_soma_update_core
    import nsu_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF,
    parameter int MAX_GAP = MAX_GAP_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input word
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [IDX_W-1:0]      i_neuron_index,
    input  logic signed [P_W-1:0] i_input_current,
    input  logic signed [P_W-1:0] i_bias_current,
    input  logic [TS_W-1:0]       i_timestep_now,
    input  logic                  i_forced,
    // result word
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_neuron_out,
    output logic                  o_fired,
    output logic                  o_reverse_hit,
    output logic signed [P_W-1:0] o_new_potential,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // register bank, always ready
    nsu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer: clear, accept, read, leak loop, sum, decide, push
    nsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // memories, leak unit, thresholds, jitter, output register
    nsu_datapath #(
        .NEURONS (NEURONS),
        .MAX_GAP (MAX_GAP)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_neuron_index  (i_neuron_index),
        .i_input_current (i_input_current),
        .i_bias_current  (i_bias_current),
        .i_timestep_now  (i_timestep_now),
        .i_forced        (i_forced),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_neuron_out    (o_neuron_out),
        .o_fired         (o_fired),
        .o_reverse_hit   (o_reverse_hit),
        .o_new_potential (o_new_potential)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for neuron_soma_update_core: directed table, then random phases.
// Depends on nsu_pkg and core RTL; expected words: in-bench model or typed table rows.
module testbench;
    import nsu_pkg::*;

    localparam int     CYCLE_LIMIT  = 4_000_000;
    localparam int     RANDOM_WORDS = 1900;
    localparam int     GAP_CAP      = MAX_GAP_DEF;
    localparam longint P_HI         = 64'sd2147483647;
    localparam longint P_LO         = -64'sd2147483648;

    // one input word and one result word, as seen at the ports
    typedef struct packed {
        logic [IDX_W-1:0]      neuron;
        logic signed [P_W-1:0] current;
        logic signed [P_W-1:0] bias;
        logic [TS_W-1:0]       ts;
        logic                  forced;
    } t_soma_in;

    typedef struct packed {
        logic [IDX_W-1:0]      neuron;
        logic                  fired;
        logic                  rev;
        logic signed [P_W-1:0] potential;
    } t_soma_out;

    // directed table row: a register write, or a word with an optional typed result
    typedef struct packed {
        logic                  is_write;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] value;
        t_soma_in              word;
        logic                  typed;
        t_soma_out             result;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [IDX_W-1:0]      i_neuron_index = '0;
    logic signed [P_W-1:0] i_input_current = '0;
    logic signed [P_W-1:0] i_bias_current = '0;
    logic [TS_W-1:0]       i_timestep_now = '0;
    logic                  i_forced = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [IDX_W-1:0]      o_neuron_out;
    logic                  o_fired;
    logic                  o_reverse_hit;
    logic signed [P_W-1:0] o_new_potential;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // model state: per-neuron potential and first leak step still owed
    logic signed [P_W-1:0] potential_mem [NEURONS_DEF];
    logic [TS_W-1:0]       leak_due [NEURONS_DEF];
    logic [15:0]           jitter_lfsr;
    t_cfg                  soma_cfg;

    t_soma_out owed_updates[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        calm = 1'b0;     // suppresses idling on both sides

    neuron_soma_update_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver backpressure, changed only at the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end

    function automatic longint clamp32(input longint x);
        if (x > P_HI) return P_HI;
        if (x < P_LO) return P_LO;
        return x;
    endfunction

    // Updates the model state for one accepted word and returns its result.
    function automatic t_soma_out soma_predict(input t_soma_in w);
        t_soma_out       r;
        longint          p, v, th, rth, leak, mag, steps, cur, bias;
        logic [TS_W-1:0] due;
        r.neuron = w.neuron;
        r.fired  = 1'b0;
        r.rev    = 1'b0;
        p     = potential_mem[w.neuron];
        cur   = w.current;
        bias  = w.bias;
        th    = $signed(soma_cfg.fire_th);
        rth   = $signed(soma_cfg.rev_th);
        leak  = soma_cfg.leak_amount;
        steps = 0;
        due   = leak_due[w.neuron];
        // catch up on owed leak; an earlier timestep than owed leaks nothing
        if (w.ts >= due) begin
            steps = longint'(w.ts) - longint'(due) + 1;
            if (steps > GAP_CAP) steps = GAP_CAP;
            leak_due[w.neuron] = w.ts + 16'd1;
        end
        case (soma_cfg.model)
            MODEL_LIF: begin
                for (int k = 0; k < steps && p != 0; k++) begin
                    mag = (p < 0) ? -p : p;
                    mag = (mag * leak) >> 16;
                    p   = (p < 0) ? -mag : mag;
                end
            end
            MODEL_LINEAR: p = clamp32(p + steps * leak);
            MODEL_TOWARD_ZERO: begin
                // may overshoot zero; saturation only after all steps
                for (int k = 0; k < steps; k++) begin
                    if (p > 0) p -= leak;
                    else if (p < 0) p += leak;
                end
                p = clamp32(p);
            end
            default: ;
        endcase
        p = clamp32(p + cur + bias);
        if (soma_cfg.model == MODEL_LIF || soma_cfg.model == MODEL_IF) begin
            if (w.forced ? (p > th) : (p >= th)) begin
                r.fired = 1'b1;
                p = $signed(soma_cfg.rst_level);
            end
        end else begin
            v = p;
            if (soma_cfg.jitter_mask != 0) begin
                jitter_lfsr = {jitter_lfsr[0] ^ jitter_lfsr[2] ^ jitter_lfsr[3] ^ jitter_lfsr[5],
                               jitter_lfsr[15:1]};
                v += longint'(jitter_lfsr & soma_cfg.jitter_mask);
            end
            if (v >= th) begin
                r.fired = 1'b1;
                case (soma_cfg.pos_mode)
                    RST_HARD: p = $signed(soma_cfg.rst_level);
                    RST_SOFT: p = clamp32(p - th);
                    RST_SAT:  p = th;
                    default:  ;
                endcase
            end else if (v <= rth) begin
                r.rev = 1'b1;
                case (soma_cfg.rev_mode)
                    RST_HARD: p = $signed(soma_cfg.rev_level);
                    RST_SOFT: p = clamp32(p + rth);
                    RST_SAT:  p = rth;
                    default:  ;
                endcase
            end
        end
        potential_mem[w.neuron] = p[P_W-1:0];
        r.potential = p[P_W-1:0];
        return r;
    endfunction

    // wide spread of magnitudes, with the extremes now and then
    function automatic logic signed [P_W-1:0] spread32();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            default: return $signed($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_plan_row reg_row(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        t_plan_row row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.value    = value;
        return row;
    endfunction

    function automatic t_plan_row word_row(input logic [IDX_W-1:0] n, input logic signed [P_W-1:0] cur,
                                           input logic signed [P_W-1:0] bias,
                                           input logic [TS_W-1:0] ts, input logic forced);
        t_plan_row row;
        row = '0;
        row.word = '{neuron: n, current: cur, bias: bias, ts: ts, forced: forced};
        return row;
    endfunction

    function automatic t_plan_row known_row(input logic [IDX_W-1:0] n, input logic signed [P_W-1:0] cur,
                                            input logic signed [P_W-1:0] bias,
                                            input logic [TS_W-1:0] ts, input logic forced,
                                            input logic fired, input logic rev,
                                            input logic signed [P_W-1:0] pot);
        t_plan_row row;
        row = word_row(n, cur, bias, ts, forced);
        row.typed  = 1'b1;
        row.result = '{neuron: n, fired: fired, rev: rev, potential: pot};
        return row;
    endfunction

    // Drives one word from the falling edge, holding it until the core takes it.
    task automatic send_word(input t_soma_in w, input logic typed, input t_soma_out known);
        t_soma_out r;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_neuron_index  <= w.neuron;
        i_input_current <= w.current;
        i_bias_current  <= w.bias;
        i_timestep_now  <= w.ts;
        i_forced        <= w.forced;
        do @(posedge i_clk); while (o_in_stall);
        r = soma_predict(w);
        if (typed) r = known;
        owed_updates.push_back(r);
    endtask

    // Drops valid and waits until every outstanding result word has come back.
    // Each word yields one result, so an empty queue means the core is idle.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_updates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODEL:     soma_cfg.model       = t_model'(value[1:0]);
            CFG_FIRE_TH:   soma_cfg.fire_th     = value;
            CFG_REV_TH:    soma_cfg.rev_th      = value;
            CFG_RST_LEVEL: soma_cfg.rst_level   = value;
            CFG_REV_LEVEL: soma_cfg.rev_level   = value;
            CFG_LEAK:      soma_cfg.leak_amount = value[LEAK_W-1:0];
            CFG_RST_MODES: begin
                soma_cfg.pos_mode = t_rmode'(value[1:0]);
                soma_cfg.rev_mode = t_rmode'(value[3:2]);
            end
            CFG_JIT_MASK:  soma_cfg.jitter_mask = value[MASK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker: every accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_soma_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_updates.size() == 0) begin
                $error("unexpected result word for neuron %0d", o_neuron_out);
                mismatches++;
            end else begin
                want = owed_updates.pop_front();
                if (o_neuron_out !== want.neuron) begin
                    $error("neuron_out: expected %0d, got %0d", want.neuron, o_neuron_out);
                    mismatches++;
                end
                if (o_fired !== want.fired) begin
                    $error("fired: expected %0d, got %0d", want.fired, o_fired);
                    mismatches++;
                end
                if (o_reverse_hit !== want.rev) begin
                    $error("reverse_hit: expected %0d, got %0d", want.rev, o_reverse_hit);
                    mismatches++;
                end
                if (o_new_potential !== want.potential) begin
                    $error("new_potential: expected %0d, got %0d",
                           want.potential, o_new_potential);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: generous bound on the slowest legal run (every word at full
    // leak catch-up, plus stalls and the clearing pass after reset).
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        t_plan_row        directed_plan[$];
        t_soma_in         w;
        t_model           model;
        logic signed [P_W-1:0] th, rth;
        logic [IDX_W-1:0] hot [8];
        logic [TS_W-1:0]  ts_cur;
        int               phase, burst, roll, words_sent;

        foreach (potential_mem[i]) begin
            potential_mem[i] = '0;
            leak_due[i]      = '0;
        end
        jitter_lfsr = LFSR_SEED;
        soma_cfg = '0;
        soma_cfg.model       = MODEL_LIF;
        soma_cfg.leak_amount = '1;
        soma_cfg.pos_mode    = RST_HARD;
        soma_cfg.rev_mode    = RST_HARD;

        // Directed table. Typed results are the ones obvious by hand; the
        // jitter rows go through the model.
        directed_plan = '{
            // reset config: LIF, threshold 0, so an all-zero word fires
            known_row(8'd0, 0, 0, 16'd0, 1'b0, 1'b1, 1'b0, 0),
            // forced needs strictly above threshold
            known_row(8'd0, 0, 0, 16'd0, 1'b1, 1'b0, 1'b0, 0),
            reg_row(CFG_FIRE_TH, 32'h7FFF_FFFF),
            // extremes: max index, max currents, last timestep (catch-up cap, wrap)
            known_row(8'd255, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0,
                      1'b1, 1'b0, 0),
            known_row(8'd255, 32'sh7FFF_FFFF, 0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 32'sh7FFF_FFFF),
            // after the wrap, timestep 0 is owed again; sum saturates low
            known_row(8'd255, 32'sh8000_0000, 32'sh8000_0000, 16'd0, 1'b0,
                      1'b0, 1'b0, 32'sh8000_0000),
            reg_row(CFG_MODEL, MODEL_IF),
            reg_row(CFG_FIRE_TH, 100),
            reg_row(CFG_RST_LEVEL, -5),
            known_row(8'd1, 60, 40, 16'd10, 1'b1, 1'b0, 1'b0, 100),
            known_row(8'd1, 0, 0, 16'd20, 1'b0, 1'b1, 1'b0, -5),
            // LIF at half decay per step
            reg_row(CFG_MODEL, MODEL_LIF),
            reg_row(CFG_LEAK, 32768),
            reg_row(CFG_FIRE_TH, 32'h7FFF_FFFF),
            known_row(8'd2, 1000, 0, 16'd0, 1'b0, 1'b0, 1'b0, 1000),
            known_row(8'd2, 0, 0, 16'd3, 1'b0, 1'b0, 1'b0, 125),
            known_row(8'd2, -1000, 0, 16'd4, 1'b0, 1'b0, 1'b0, -938),
            known_row(8'd2, 0, 0, 16'd5, 1'b0, 1'b0, 1'b0, -469),
            // linear leak, soft fire reset, reverse reset none
            reg_row(CFG_MODEL, MODEL_LINEAR),
            reg_row(CFG_LEAK, 65535),
            reg_row(CFG_RST_MODES, {RST_NONE, RST_SOFT}),
            reg_row(CFG_FIRE_TH, 1000),
            reg_row(CFG_REV_TH, -1000),
            known_row(8'd3, 0, 0, 16'd2, 1'b0, 1'b1, 1'b0, 195605),
            // timestep behind the owed one: no leak
            known_row(8'd3, -200000, 0, 16'd2, 1'b1, 1'b0, 1'b1, -4395),
            // zero leak, saturate fire reset, hard reverse reset
            reg_row(CFG_LEAK, 0),
            reg_row(CFG_RST_MODES, {RST_HARD, RST_SAT}),
            reg_row(CFG_REV_LEVEL, 7),
            known_row(8'd3, 5000, 0, 16'd100, 1'b0, 1'b0, 1'b0, 605),
            known_row(8'd3, 2000, 0, 16'd101, 1'b0, 1'b1, 1'b0, 1000),
            known_row(8'd3, -3000, 0, 16'd102, 1'b0, 1'b0, 1'b1, 7),
            // toward-zero leak overshoots past zero; soft reverse reset
            reg_row(CFG_MODEL, MODEL_TOWARD_ZERO),
            reg_row(CFG_LEAK, 100),
            reg_row(CFG_RST_MODES, {RST_SOFT, RST_HARD}),
            known_row(8'd4, 50, 0, 16'd0, 1'b0, 1'b0, 1'b0, 50),
            known_row(8'd4, 0, 0, 16'd1, 1'b0, 1'b0, 1'b0, -50),
            known_row(8'd4, -2000, 0, 16'd5, 1'b0, 1'b0, 1'b1, -3050),
            // soft reset saturates high
            reg_row(CFG_FIRE_TH, 32'h8000_0000),
            reg_row(CFG_RST_MODES, {RST_HARD, RST_SOFT}),
            known_row(8'd5, 32'sh7FFF_FFFF, 0, 16'd0, 1'b0, 1'b1, 1'b0, 32'sh7FFF_FFFF),
            // linear leak saturates, capped gap; fire with reset none
            reg_row(CFG_MODEL, MODEL_LINEAR),
            reg_row(CFG_LEAK, 65535),
            reg_row(CFG_FIRE_TH, 32'h7FFF_FFFF),
            reg_row(CFG_REV_TH, 32'h8000_0000),
            reg_row(CFG_RST_MODES, {RST_NONE, RST_NONE}),
            known_row(8'd5, 0, 0, 16'd300, 1'b0, 1'b1, 1'b0, 32'sh7FFF_FFFF),
            // full jitter mask
            reg_row(CFG_JIT_MASK, 32'h0000_FFFF),
            word_row(8'd6, 0, 0, 16'd0, 1'b0),
            word_row(8'd6, -1, -1, 16'd1, 1'b1),
            word_row(8'd7, 32'sh8000_0000, 0, 16'd2, 1'b0)
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_write) begin
                wait_for_results();
                write_register(directed_plan[i].reg_idx, directed_plan[i].value);
            end else begin
                send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].result);
            end
        end

        // Random phases: fresh register set each phase, words mostly on a few
        // hot neurons with slowly advancing time so state builds up.
        ts_cur     = 16'd10;
        words_sent = 0;
        phase      = 0;
        while (words_sent < RANDOM_WORDS) begin
            wait_for_results();
            calm = (phase == 2 || phase == 3);
            model = (phase < 4) ? t_model'(phase) : t_model'($urandom_range(0, 3));
            th  = spread32();
            rth = spread32();
            if (th < 0) th = -th;
            if (rth > 0) rth = -rth;
            write_register(CFG_MODEL, model);
            write_register(CFG_FIRE_TH, th);
            write_register(CFG_REV_TH, rth);
            write_register(CFG_RST_LEVEL, spread32());
            write_register(CFG_REV_LEVEL, spread32());
            case ($urandom_range(0, 4))
                0:       write_register(CFG_LEAK, 0);
                1:       write_register(CFG_LEAK, 65535);
                2:       write_register(CFG_LEAK, $urandom_range(0, 65535));
                default: write_register(CFG_LEAK, 65535 - $urandom_range(0, 4000));
            endcase
            write_register(CFG_RST_MODES, $urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0, 1:    write_register(CFG_JIT_MASK, 0);
                2:       write_register(CFG_JIT_MASK, 65535);
                default: write_register(CFG_JIT_MASK, $urandom_range(0, 65535));
            endcase
            foreach (hot[i]) hot[i] = $urandom_range(0, 255);

            burst = $urandom_range(80, 160);
            for (int n = 0; n < burst; n++) begin
                roll = $urandom_range(0, 99);
                if (roll >= 97) begin
                    // jump anywhere, sometimes right before the wrap
                    ts_cur = (roll == 99) ? 16'hFFFF - $urandom_range(0, 3)
                                          : $urandom_range(0, 65535);
                end else if (roll >= 88) begin
                    ts_cur += $urandom_range(2, 40);
                end else if (roll >= 60) begin
                    ts_cur += 16'd1;
                end
                w.neuron  = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, 7)]
                                                         : $urandom_range(0, 255);
                w.current = spread32();
                w.bias    = ($urandom_range(0, 3) == 0) ? spread32()
                                                        : $signed($urandom) >>> 24;
                w.ts      = ts_cur;
                w.forced  = $urandom_range(0, 1);
                send_word(w, 1'b0, '0);
                words_sent++;
                // occasional hold-off until the core has emptied
                if ($urandom_range(0, 199) == 0) wait_for_results();
            end
            phase++;
        end

        wait_for_results();
        // quiet tail: longest catch-up plus margin, to catch stray result words
        repeat (400) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
design/nsu_pkg.sv
design/nsu_cfg_regs.sv
design/nsu_ctrl.sv
design/nsu_datapath.sv
design/neuron_soma_update_core.sv
bench/testbench.sv
